>>> hw/rtl/plm_pkg.sv
`default_nettype none

package plm_pkg;

    localparam int SAMPLE_W = 8;
    localparam int TICK_W   = 6;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_STORE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam int DECAY_PERIOD = 4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SAMPLE_W-1:0] sample;
        logic [TICK_W-1:0]   tick_count;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] peak;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic store;
        logic restart;
        logic scan_start;
        logic scan_rd;
        logic fold;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/plm_ram.sv
`default_nettype none

module plm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/plm_ctrl.sv
`default_nettype none

module plm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [plm_pkg::OP_W-1:0]  i_op,
    output logic                           o_stall,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output plm_pkg::t_dp_cmd               o_cmd,
    input  wire plm_pkg::t_dp_status       i_status
);

    import plm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_fold;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid && i_op == OP_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.fold = r_fold;
        o_stall    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    unique case (i_op)
                        OP_STORE:   o_cmd.store      = 1'b1;
                        OP_TICK:    o_cmd.scan_start = 1'b1;
                        OP_RESTART: o_cmd.restart    = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: ;
            ST_FIN: begin
                o_cmd.finish = out_free;
            end
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.finish || (r_out_valid && i_stall);
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_fold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fold      <= o_cmd.scan_rd;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/plm_dp.sv
`default_nettype none

module plm_dp #(
    parameter int RING_DEPTH = 256,
    parameter int WINDOW_LEN = 125
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire plm_pkg::t_in_word   i_word,
    input  wire plm_pkg::t_dp_cmd    i_cmd,
    output plm_pkg::t_dp_status      o_status,
    output plm_pkg::t_out_word       o_word
);

    import plm_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    logic [IDX_W-1:0]    r_wr_idx;
    logic [IDX_W-1:0]    r_clr_addr;
    logic [IDX_W-1:0]    r_rd_addr;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SAMPLE_W-1:0] r_peak;
    logic                r_decay;
    t_out_word           r_out;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_wa;
    logic [SAMPLE_W-1:0] ram_wd;
    logic [SAMPLE_W-1:0] ram_q;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] peak_up;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
    endfunction

    assign ram_we = i_cmd.clr || i_cmd.store;
    assign ram_wa = i_cmd.clr ? r_clr_addr : r_wr_idx;
    assign ram_wd = i_cmd.clr ? '0 : i_word.sample;

    plm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (ram_q)
    );

    assign o_status.clr_last  = (r_clr_addr == IDX_LAST);
    assign o_status.scan_last = (r_cnt == CNT_W'(1));

    assign level   = (r_hi >= r_lo) ? r_hi - r_lo : '0;
    assign peak_up = (level > r_peak) ? level : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_clr_addr <= '0;
            r_peak     <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= idx_next(r_clr_addr);
            end
            if (i_cmd.store) begin
                r_wr_idx <= idx_next(r_wr_idx);
            end else if (i_cmd.restart) begin
                r_wr_idx <= '0;
            end
            if (i_cmd.finish) begin
                r_peak <= (peak_up != '0 && r_decay) ? peak_up - SAMPLE_W'(1) : peak_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_addr <= idx_prev(r_wr_idx);
            r_cnt     <= CNT_W'(WINDOW_LEN);
            r_lo      <= SAMPLE_MAX;
            r_hi      <= '0;
            r_decay   <= ((i_word.tick_count % DECAY_PERIOD) == 0);
        end else begin
            if (i_cmd.scan_rd) begin
                r_rd_addr <= idx_prev(r_rd_addr);
                r_cnt     <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.fold) begin
                if (ram_q < r_lo) begin
                    r_lo <= ram_q;
                end
                if (ram_q > r_hi) begin
                    r_hi <= ram_q;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out.level <= level;
            r_out.peak  <= peak_up;
        end
    end

    assign o_word = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/audio_peak_to_peak_level_meter.sv
// store and restart words are taken while idle; unused operation codes are taken and dropped
// a tick word makes one ring read per window entry through the single read port, then waits
// for the last read data, then forms the result
// the result sits in an output register; store and restart words are taken while it waits
// reset is synchronous, active low; afterwards the ring is cleared one entry per cycle,
// all RING_DEPTH entries, with the input stalled
`default_nettype none

module audio_peak_to_peak_level_meter #(
    parameter int RING_DEPTH = 256,
    parameter int WINDOW_LEN = 125
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire plm_pkg::t_in_word   i_word,
    output logic                     o_stall,
    output logic                     o_valid,
    output plm_pkg::t_out_word       o_word,
    input  wire logic                i_stall
);

    import plm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    plm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_word.operation),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    plm_dp #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_status (status),
        .o_word   (o_word)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.peak >= o_word.level)
        else $error("peak below level");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_valid)
        else $error("result not presented");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.store, cmd.restart, cmd.scan_start, cmd.scan_rd, cmd.finish}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire
